// ----- design/cbs_pkg.sv -----
// shared constants, types and helpers for the centered binomial sampler
package cbs_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CountW     = 11;
  localparam int unsigned CoefW      = 3;
  localparam int unsigned BufW       = 6;
  localparam int unsigned AccW       = BufW + ByteW;
  localparam int unsigned TotalW     = 4;
  localparam int unsigned MaxDegree  = 2047;
  localparam int unsigned CountReset = 761;

  localparam logic [TotalW-1:0] GroupEta2 = TotalW'(4);
  localparam logic [TotalW-1:0] GroupEta3 = TotalW'(6);

  typedef enum logic {
    CfgEtaMode    = 1'b0,
    CfgCoeffCount = 1'b1
  } cfg_reg_e;

  typedef logic [CountW-1:0] count_t;

  function automatic logic [1:0] ones3(input logic [2:0] v);
    logic [1:0] c;
    c = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    return c;
  endfunction

endpackage

// ----- design/cbs_group_decode.sv -----
// turns one 4-bit or 6-bit stream group into a signed coefficient
module cbs_group_decode (
  input  logic                             eta3_i,
  input  logic [cbs_pkg::BufW-1:0]         group_i,
  output logic signed [cbs_pkg::CoefW-1:0] coefficient_o
);

  logic [2:0] low_bits;
  logic [2:0] high_bits;
  logic [1:0] low_ones;
  logic [1:0] high_ones;

  always_comb begin
    if (eta3_i) begin
      low_bits  = group_i[2:0];
      high_bits = group_i[5:3];
    end else begin
      low_bits  = {1'b0, group_i[1:0]};
      high_bits = {1'b0, group_i[3:2]};
    end
  end

  assign low_ones      = cbs_pkg::ones3(low_bits);
  assign high_ones     = cbs_pkg::ones3(high_bits);
  assign coefficient_o = signed'({1'b0, low_ones} - {1'b0, high_ones});

endmodule

// ----- design/centered_binomial_sampler.sv -----
// top level of the centered binomial sampler
//
// Random bytes come in on the input channel (in_valid_i / in_stall_o) and are read
// as one bit stream, bit 0 of each byte first. In eta-2 mode every 4 bits make a
// coefficient, in eta-3 mode every 6 bits; each coefficient leaves on the output
// channel (out_valid_o / out_stall_i) with last_o set on the final coefficient of a
// polynomial, after which the rest of that byte is dropped.
// A byte is taken into a working register; while the receiver does not stall, the
// single group decoder turns one group per cycle into the one-beat-per-cycle
// output register, so a coefficient passes through the working register and then
// the output register. The next byte is taken in the cycle the last group of the
// current byte is decoded; a byte gives two groups in eta-2 mode, one or two in
// eta-3 mode, and none after the group that ends the polynomial.
// The configuration channel (cfg_valid_i / cfg_ready_o) is always ready; index 0
// sets the mode and restarts the polynomial, index 1 sets the coefficient count.
// Reset empties the bit buffer, zeroes the emitted-coefficient counter and selects
// eta 2 with 761 coefficients. While the receiver stalls, the output beat holds and
// the input channel stalls as soon as the working register has a group to hand on.
module centered_binomial_sampler #(
  parameter int unsigned MaxDegree = cbs_pkg::MaxDegree
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [cbs_pkg::ByteW-1:0]         rand_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cbs_pkg::CoefW-1:0]  coefficient_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  cbs_pkg::cfg_reg_e                 cfg_index_i,
  input  logic [cbs_pkg::CountW-1:0]        cfg_data_i
);

  localparam int unsigned AccW   = cbs_pkg::AccW;
  localparam int unsigned TotalW = cbs_pkg::TotalW;
  localparam int unsigned BufW   = cbs_pkg::BufW;

  logic                     eta3_q;
  cbs_pkg::count_t          coeff_count_q;
  cbs_pkg::count_t          emitted_q, emitted_d;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [TotalW-1:0]        total_q, total_d;
  logic                     busy_q, busy_d;
  logic                     second_q, second_d;
  logic                     out_valid_q;
  logic signed [cbs_pkg::CoefW-1:0] coef_q;
  logic                     last_q;

  logic [TotalW-1:0]        gsize;
  cbs_pkg::count_t          limit;
  cbs_pkg::count_t          emitted_inc;
  logic signed [cbs_pkg::CoefW-1:0] coef_new;
  logic                     have_grp;
  logic                     out_free;
  logic                     emit;
  logic                     emit_last;
  logic                     done_after;
  logic                     finish;
  logic                     in_accept;
  logic                     cfg_write;
  logic [AccW-1:0]          acc_shift;
  logic [TotalW-1:0]        total_sub;
  logic [AccW-1:0]          base_acc;
  logic [TotalW-1:0]        base_total;

  cbs_group_decode u_decode (
    .eta3_i        (eta3_q),
    .group_i       (acc_q[BufW-1:0]),
    .coefficient_o (coef_new)
  );

  // effective polynomial length
  always_comb begin
    if (coeff_count_q == '0) begin
      limit = cbs_pkg::count_t'(1);
    end else if (32'(coeff_count_q) > MaxDegree) begin
      limit = cbs_pkg::count_t'(MaxDegree);
    end else begin
      limit = coeff_count_q;
    end
  end

  assign gsize       = eta3_q ? cbs_pkg::GroupEta3 : cbs_pkg::GroupEta2;
  assign have_grp    = busy_q && (total_q >= gsize);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign emit        = have_grp && out_free;
  assign emitted_inc = emitted_q + cbs_pkg::count_t'(1);
  assign emit_last   = (emitted_inc >= limit);
  assign acc_shift   = acc_q >> gsize;
  assign total_sub   = total_q - gsize;
  assign done_after  = emit_last || second_q || (total_sub < gsize);
  assign finish      = busy_q && (!have_grp || (out_free && done_after));
  assign in_stall_o  = busy_q && !finish;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // bits left over once the current byte is done
  always_comb begin
    if (!busy_q || !have_grp) begin
      base_acc   = acc_q;
      base_total = total_q;
    end else if (emit_last) begin
      base_acc   = '0;
      base_total = '0;
    end else begin
      base_acc   = acc_shift;
      base_total = total_sub;
    end
  end

  always_comb begin
    acc_d     = acc_q;
    total_d   = total_q;
    busy_d    = busy_q;
    second_d  = second_q;
    emitted_d = emitted_q;
    if (emit) begin
      emitted_d = emit_last ? '0 : emitted_inc;
    end
    if (in_accept) begin
      acc_d    = AccW'(base_acc[BufW-1:0])
               | (AccW'(rand_byte_i) << base_total[2:0]);
      total_d  = base_total + TotalW'(cbs_pkg::ByteW);
      busy_d   = 1'b1;
      second_d = 1'b0;
    end else if (finish) begin
      acc_d    = base_acc;
      total_d  = base_total;
      busy_d   = 1'b0;
      second_d = 1'b0;
    end else if (emit) begin
      acc_d    = acc_shift;
      total_d  = total_sub;
      second_d = 1'b1;
    end
    if (cfg_write && (cfg_index_i == cbs_pkg::CfgEtaMode)) begin
      acc_d     = '0;
      total_d   = '0;
      emitted_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      total_q   <= '0;
      busy_q    <= 1'b0;
      second_q  <= 1'b0;
      emitted_q <= '0;
    end else begin
      acc_q     <= acc_d;
      total_q   <= total_d;
      busy_q    <= busy_d;
      second_q  <= second_d;
      emitted_q <= emitted_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta3_q        <= 1'b0;
      coeff_count_q <= cbs_pkg::count_t'(cbs_pkg::CountReset);
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        cbs_pkg::CfgEtaMode:    eta3_q        <= cfg_data_i[0];
        cbs_pkg::CfgCoeffCount: coeff_count_q <= cfg_data_i;
        default:                eta3_q        <= eta3_q;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      coef_q <= coef_new;
      last_q <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = coef_q;
  assign last_o        = last_q;

endmodule

// ----- verif/centered_binomial_sampler_tb.sv -----
// self-checking testbench for the centered binomial sampler, with its own predictor and checker
module centered_binomial_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned SettleGap  = 8;
  localparam int unsigned TailWait   = 20;
  localparam int unsigned MaxReports = 10;

  localparam int unsigned ByteW      = cbs_pkg::ByteW;
  localparam int unsigned CountW     = cbs_pkg::CountW;
  localparam int unsigned CoefW      = cbs_pkg::CoefW;
  localparam int unsigned BufW       = cbs_pkg::BufW;
  localparam int unsigned AccW       = cbs_pkg::AccW;
  localparam int unsigned MaxDegree  = cbs_pkg::MaxDegree;
  localparam int unsigned CountReset = cbs_pkg::CountReset;

  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic                    last;
  } coef_beat_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ByteW-1:0]        rand_byte_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [CoefW-1:0] coefficient_o;
  logic                    last_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  cbs_pkg::cfg_reg_e       cfg_index_i;
  logic [CountW-1:0]       cfg_data_i;

  // predictor state
  logic                eta3_q;
  cbs_pkg::count_t     coeff_limit_q;
  logic [BufW-1:0]     stream_bits_q;
  logic [2:0]          bits_held_q;
  cbs_pkg::count_t     emitted_q;

  coef_beat_t  pending_coefs[$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  centered_binomial_sampler uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rand_byte_i   (rand_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .coefficient_o (coefficient_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic sample_coefficients(input logic [ByteW-1:0] rnd);
    logic [AccW-1:0] acc;
    logic [BufW-1:0] grp;
    int unsigned     half, gsize, total, lim, lo_ones, hi_ones, n;
    coef_beat_t      beat;
    half  = eta3_q ? 3 : 2;
    gsize = 2 * half;
    acc   = AccW'(stream_bits_q) | (AccW'(rnd) << bits_held_q);
    total = bits_held_q + ByteW;
    lim   = (coeff_limit_q == 0) ? 1 : coeff_limit_q;
    if (lim > MaxDegree) lim = MaxDegree;
    n = 0;
    while (total >= gsize && n < 2) begin
      grp       = acc[BufW-1:0] & BufW'((1 << gsize) - 1);
      lo_ones   = $countones(grp & BufW'((1 << half) - 1));
      hi_ones   = $countones((grp >> half) & BufW'((1 << half) - 1));
      acc       = acc >> gsize;
      total     = total - gsize;
      emitted_q = emitted_q + 1'b1;
      beat.coef = CoefW'(lo_ones - hi_ones);
      beat.last = (emitted_q >= lim);
      pending_coefs.push_back(beat);
      n++;
      if (beat.last) begin
        acc       = '0;
        total     = 0;
        emitted_q = '0;
        break;
      end
    end
    stream_bits_q = acc[BufW-1:0];
    bits_held_q   = total[2:0];
  endtask

  task automatic send_byte(input logic [ByteW-1:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    rand_byte_i <= rnd;
    do @(posedge clk_i); while (in_stall_o);
    sample_coefficients(rnd);
  endtask

  // hold the input back until every expected coefficient has left the block
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk_i);
    repeat (SettleGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input cbs_pkg::cfg_reg_e idx, input logic [CountW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      cbs_pkg::CfgEtaMode: begin
        eta3_q        = data[0];
        stream_bits_q = '0;
        bits_held_q   = '0;
        emitted_q     = '0;
      end
      cbs_pkg::CfgCoeffCount: coeff_limit_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("FAIL centered_binomial_sampler");
        $finish;
      end else if (out_valid_o && !out_stall_i) begin
        if (pending_coefs.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t unexpected beat: coef %0d last %0b", $realtime,
                     coefficient_o, last_o);
        end else if (pending_coefs[0].coef !== coefficient_o ||
                     pending_coefs[0].last !== last_o) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("%0t mismatch: coef exp %0d got %0d, last exp %0b got %0b", $realtime,
                     pending_coefs[0].coef, coefficient_o, pending_coefs[0].last, last_o);
          void'(pending_coefs.pop_front());
        end else begin
          void'(pending_coefs.pop_front());
        end
      end
    end
  end

  task automatic test_reset_defaults();
    logic [ByteW-1:0] pattern[8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h03, 8'h0C, 8'h5A, 8'hA5};
    foreach (pattern[i]) send_byte(pattern[i]);
  endtask

  task automatic test_eta3_groups();
    logic [ByteW-1:0] pattern[6] = '{8'h07, 8'hE0, 8'hFF, 8'h00, 8'h38, 8'h8E};
    settle_block();
    write_reg(cbs_pkg::CfgEtaMode, 11'h001);
    foreach (pattern[i]) send_byte(pattern[i]);
  endtask

  // a zero count behaves as one: every coefficient is last
  task automatic test_zero_count();
    settle_block();
    write_reg(cbs_pkg::CfgCoeffCount, '0);
    send_byte(8'hC7);
    send_byte(8'h3B);
    settle_block();
    write_reg(cbs_pkg::CfgEtaMode, 11'h7FE);
    send_byte(8'h96);
  endtask

  task automatic test_count_lowered();
    settle_block();
    write_reg(cbs_pkg::CfgCoeffCount, 11'd20);
    write_reg(cbs_pkg::CfgEtaMode, 11'h001);
    repeat (4) send_byte(8'($urandom_range(255)));
    settle_block();
    write_reg(cbs_pkg::CfgCoeffCount, 11'd3);
    send_byte(8'h6D);
    send_byte(8'hB2);
  endtask

  // mode write mid polynomial with bits held drops them
  task automatic test_mode_restart();
    settle_block();
    write_reg(cbs_pkg::CfgCoeffCount, 11'd9);
    send_byte(8'hF1);
    settle_block();
    write_reg(cbs_pkg::CfgEtaMode, 11'h7FF);
    send_byte(8'h1E);
    send_byte(8'hE1);
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned       sent, chunk;
    logic [CountW-1:0] count;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      settle_block();
      if ($urandom_range(1)) write_reg(cbs_pkg::CfgEtaMode, CountW'($urandom_range(2047)));
      case ($urandom_range(9))
        0:       count = 11'd1;
        1:       count = 11'd2047;
        2:       count = '0;
        3:       count = 11'(CountReset);
        4, 5, 6: count = CountW'($urandom_range(16, 1));
        default: count = CountW'($urandom_range(2047));
      endcase
      write_reg(cbs_pkg::CfgCoeffCount, count);
      chunk = $urandom_range(60, 15);
      repeat (chunk) begin
        if ($urandom_range(49) == 0) settle_block();
        case ($urandom_range(7))
          0:       send_byte(8'h00);
          1:       send_byte(8'hFF);
          default: send_byte(8'($urandom_range(255)));
        endcase
      end
      sent += chunk;
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rand_byte_i    = '0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = cbs_pkg::CfgEtaMode;
    cfg_data_i     = '0;
    mismatches     = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 32;
    recv_stall_pct = 49;
    eta3_q         = 1'b0;
    coeff_limit_q  = cbs_pkg::count_t'(CountReset);
    stream_bits_q  = '0;
    bits_held_q    = '0;
    emitted_q      = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_eta3_groups();
    test_zero_count();
    test_count_lowered();
    test_mode_restart();
    test_random_traffic(32, 49, 350);
    test_random_traffic(49, 32, 350);
    test_random_traffic(0, 0, 350);

    settle_block();
    repeat (TailWait) @(posedge clk_i);
    if (mismatches == 0 && pending_coefs.size() == 0) begin
      $display("PASS centered_binomial_sampler");
    end else begin
      $display("FAIL centered_binomial_sampler");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/cbs_pkg.sv
design/cbs_group_decode.sv
design/centered_binomial_sampler.sv
verif/centered_binomial_sampler_tb.sv
